// ----- hdl/efe_pkg.sv -----
// Shared types and constants for the escaped frame encoder.
// Used by efe_front, efe_queue, efe_back and escaped_frame_encoder; no dependencies.

package efe_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_ADDR_W  = 5;
    localparam int unsigned CFG_DATA_W  = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_START   = 3'd0;
    localparam logic [2:0] REG_END     = 3'd1;
    localparam logic [2:0] REG_ESCAPE  = 3'd2;
    localparam logic [2:0] REG_COMMAND = 3'd3;
    localparam logic [2:0] REG_ERROR   = 3'd4;

    // reset values of the registers
    localparam logic [BYTE_W-1:0] RST_START   = 8'hF0;
    localparam logic [BYTE_W-1:0] RST_END     = 8'hF1;
    localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'hF2;
    localparam logic [BYTE_W-1:0] RST_COMMAND = 8'h02;
    localparam logic [BYTE_W-1:0] RST_ERROR   = 8'h00;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] error_byte;
    } t_cfg;

    // one classified beat handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] seq;
        logic [SUM_W-1:0]  sum;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hdl/efe_front.sv -----
// Front end: accepts input beats, keeps sequence number and running sum, builds jobs.
// Depends on efe_pkg.

module efe_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  efe_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [efe_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_first_byte,
    input  logic                          i_last_byte,
    input  efe_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output efe_pkg::t_job                 o_job
);

    logic [efe_pkg::BYTE_W-1:0] r_seq, n_seq;
    logic [efe_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [efe_pkg::SUM_W-1:0]  w_base;

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && o_in_ready;

    // restart the sum from the header bytes on a new frame
    assign w_base = i_first_byte
        ? (efe_pkg::SUM_W'(i_cfg.command_byte) + efe_pkg::SUM_W'(i_cfg.error_byte))
        : r_sum;

    always_comb begin
        n_sum = r_sum;
        n_seq = r_seq;
        if (o_push) begin
            n_sum = w_base + efe_pkg::SUM_W'(i_data_byte);
            if (i_first_byte) begin
                n_seq = r_seq + 1'b1;
            end
        end
    end

    always_comb begin
        o_job.data  = i_data_byte;
        o_job.first = i_first_byte;
        o_job.last  = i_last_byte && !i_first_byte;
        o_job.seq   = r_seq;
        o_job.sum   = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
            r_sum <= '0;
        end else begin
            r_seq <= n_seq;
            r_sum <= n_sum;
        end
    end

endmodule

// ----- hdl/efe_queue.sv -----
// Short job queue between front and back, register based.
// Depends on efe_pkg.

module efe_queue #(
    parameter int unsigned Depth = efe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  efe_pkg::t_job    i_job,
    input  logic             i_pop,
    output efe_pkg::t_job    o_job,
    output efe_pkg::t_q_stat o_stat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    efe_pkg::t_job   r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push, w_pop;

    assign o_stat.full  = (r_count == FullCnt);
    assign o_stat.empty = (r_count == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_job  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/efe_back.sv -----
// Back end: walks each job through a header on a first beat, escaped payload, and sum and end byte on a closing beat.
// Depends on efe_pkg; output register decouples the sequencer from the sink.

module efe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  efe_pkg::t_cfg              i_cfg,
    input  efe_pkg::t_job              i_job,
    input  efe_pkg::t_q_stat           i_q_stat,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [efe_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_run_end,
    output logic                       o_frame_end
);

    typedef enum logic [3:0] {
        ST_BEGIN, ST_START, ST_CMD, ST_ERR, ST_SEQ,
        ST_DATA, ST_DATA_X, ST_HI, ST_HI_X, ST_LO, ST_LO_X, ST_END
    } t_state;

    t_state                     r_state, n_state;
    t_state                     w_cur;
    logic                       r_out_valid;
    logic [efe_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                       r_run_end, n_run_end;
    logic                       r_frame_end, n_frame_end;
    logic                       w_adv, w_done;
    logic [efe_pkg::BYTE_W-1:0] w_hi, w_lo, w_sel;
    logic                       w_esc;

    assign w_adv = !i_q_stat.empty && (!r_out_valid || i_out_ready);
    assign w_cur = (r_state == ST_BEGIN) ? (i_job.first ? ST_START : ST_DATA) : r_state;
    assign w_hi  = i_job.sum[efe_pkg::SUM_W-1:efe_pkg::BYTE_W];
    assign w_lo  = i_job.sum[efe_pkg::BYTE_W-1:0];

    // byte under the escape check in the current step
    always_comb begin
        unique case (w_cur)
            ST_HI, ST_HI_X: w_sel = w_hi;
            ST_LO, ST_LO_X: w_sel = w_lo;
            default:        w_sel = i_job.data;
        endcase
    end

    assign w_esc = (w_sel == i_cfg.start_byte) || (w_sel == i_cfg.end_byte)
                || (w_sel == i_cfg.escape_byte);

    always_comb begin
        n_state     = w_cur;
        n_out_byte  = w_sel;
        n_frame_end = 1'b0;
        w_done      = 1'b0;
        unique case (w_cur)
            ST_START: begin
                n_out_byte = i_cfg.start_byte;
                n_state    = ST_CMD;
            end
            ST_CMD: begin
                n_out_byte = i_cfg.command_byte;
                n_state    = ST_ERR;
            end
            ST_ERR: begin
                n_out_byte = i_cfg.error_byte;
                n_state    = ST_SEQ;
            end
            ST_SEQ: begin
                n_out_byte = i_job.seq;
                n_state    = ST_DATA;
            end
            ST_DATA: begin
                if (w_esc) begin
                    n_out_byte = i_cfg.escape_byte;
                    n_state    = ST_DATA_X;
                end else begin
                    n_state = ST_HI;
                    w_done  = !i_job.last;
                end
            end
            ST_DATA_X: begin
                n_out_byte = w_sel ^ i_cfg.escape_byte;
                n_state    = ST_HI;
                w_done     = !i_job.last;
            end
            ST_HI: begin
                if (w_esc) begin
                    n_out_byte = i_cfg.escape_byte;
                    n_state    = ST_HI_X;
                end else begin
                    n_state = ST_LO;
                end
            end
            ST_HI_X: begin
                n_out_byte = w_sel ^ i_cfg.escape_byte;
                n_state    = ST_LO;
            end
            ST_LO: begin
                if (w_esc) begin
                    n_out_byte = i_cfg.escape_byte;
                    n_state    = ST_LO_X;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_LO_X: begin
                n_out_byte = w_sel ^ i_cfg.escape_byte;
                n_state    = ST_END;
            end
            ST_END: begin
                n_out_byte  = i_cfg.end_byte;
                n_frame_end = 1'b1;
                w_done      = 1'b1;
            end
            default: begin
                n_state = ST_DATA;
            end
        endcase
        if (w_done) begin
            n_state = ST_BEGIN;
        end
        n_run_end = w_done;
    end

    assign o_pop       = w_adv && w_done;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_end   = r_run_end;
    assign o_frame_end = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BEGIN;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_run_end   <= 1'b0;
            r_frame_end <= 1'b0;
        end else begin
            if (w_adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
                r_out_byte  <= n_out_byte;
                r_run_end   <= n_run_end;
                r_frame_end <= n_frame_end;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/escaped_frame_encoder.sv -----
// Top level of the escaped frame encoder: register file, front, queue and back.
// Depends on efe_pkg, efe_front, efe_queue and efe_back.
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ----------------------------------
//  in        sink       i_in_valid / o_in_ready    i_data_byte, i_first_byte, i_last_byte
//  out       source     o_out_valid / i_out_ready  o_out_byte, o_run_end, o_frame_end
//  cfg       APB slave  psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// Each input beat yields one to seven output beats, one per cycle while the sink takes
// them: a plain mid-frame byte yields one, a header with an escaped byte six, and
// an escaped last byte followed by an escaped sum and the end byte seven.
// The front end takes a beat whenever the job queue has room; hold the input only
// when the queue is full behind a stalled sink. Synchronous active-low reset clears
// sequence number, sum, queue and sequencer; write registers only while idle.

module escaped_frame_encoder #(
    parameter int unsigned QueueDepth = efe_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [efe_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_first_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [efe_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_run_end,
    output logic                           o_frame_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [efe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [efe_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [efe_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    efe_pkg::t_cfg    r_cfg;
    efe_pkg::t_job    w_push_job, w_head_job;
    efe_pkg::t_q_stat w_q_stat;
    logic             w_push, w_pop;
    logic [2:0]       w_reg_idx;
    logic             w_cfg_wr;
    logic [efe_pkg::BYTE_W-1:0] w_rd_byte;

    // ---------------------------------------------------------------
    // Configuration registers: word addressed, write on the access phase
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[efe_pkg::CFG_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte   <= efe_pkg::RST_START;
            r_cfg.end_byte     <= efe_pkg::RST_END;
            r_cfg.escape_byte  <= efe_pkg::RST_ESCAPE;
            r_cfg.command_byte <= efe_pkg::RST_COMMAND;
            r_cfg.error_byte   <= efe_pkg::RST_ERROR;
        end else if (w_cfg_wr) begin
            // drop writes to addresses beyond the register list
            unique case (w_reg_idx)
                efe_pkg::REG_START:   r_cfg.start_byte   <= pwdata[efe_pkg::BYTE_W-1:0];
                efe_pkg::REG_END:     r_cfg.end_byte     <= pwdata[efe_pkg::BYTE_W-1:0];
                efe_pkg::REG_ESCAPE:  r_cfg.escape_byte  <= pwdata[efe_pkg::BYTE_W-1:0];
                efe_pkg::REG_COMMAND: r_cfg.command_byte <= pwdata[efe_pkg::BYTE_W-1:0];
                efe_pkg::REG_ERROR:   r_cfg.error_byte   <= pwdata[efe_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            efe_pkg::REG_START:   w_rd_byte = r_cfg.start_byte;
            efe_pkg::REG_END:     w_rd_byte = r_cfg.end_byte;
            efe_pkg::REG_ESCAPE:  w_rd_byte = r_cfg.escape_byte;
            efe_pkg::REG_COMMAND: w_rd_byte = r_cfg.command_byte;
            efe_pkg::REG_ERROR:   w_rd_byte = r_cfg.error_byte;
            default:              w_rd_byte = '0;
        endcase
    end

    assign prdata = efe_pkg::CFG_DATA_W'(w_rd_byte);

    // ---------------------------------------------------------------
    // Front end: classify the beat, advance sequence number and sum
    // ---------------------------------------------------------------
    efe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    // ---------------------------------------------------------------
    // Job queue: absorbs header and trailer bursts
    // ---------------------------------------------------------------
    efe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    // ---------------------------------------------------------------
    // Back end: emit header, stuffed payload, sum and end byte
    // ---------------------------------------------------------------
    efe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_head_job),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end),
        .o_frame_end (o_frame_end)
    );

`ifndef SYNTH
    // the closing end byte is always the final beat of its input
    a_frame_end_runs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_run_end)
        else $error("frame end without run end");

    // queue cannot be full and empty at once
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue status inconsistent");

    // front stalls exactly when the queue is full
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == !w_q_stat.full)
        else $error("input ready does not follow queue space");

    // a job leaves the queue only when the back end loads its final beat
    a_pop_loads_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid && o_run_end)
        else $error("job popped without a final beat");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for escaped_frame_encoder: directed table, then random frames.
// Depends on efe_pkg and the encoder RTL; carries its own model of the byte stuffing and sum.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // run limits, reckoned well above the slowest legal run
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_BEATS     = 36;
    localparam int unsigned NUM_PHASES      = 8;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } t_row_kind;

    // one encoded output beat as the sink sees it
    typedef struct packed {
        logic [efe_pkg::BYTE_W-1:0] out_byte;
        logic                       run_end;
        logic                       frame_end;
    } t_enc_byte;

    // one row of the directed table: either a register write or an input beat;
    // a beat row may carry up to seven typed output bytes, first byte leftmost
    typedef struct packed {
        t_row_kind                  kind;
        logic [2:0]                 reg_idx;
        logic [efe_pkg::BYTE_W-1:0] value;
        logic                       is_first;
        logic                       is_last;
        logic [2:0]                 n_typed;
        logic [55:0]                typed;
    } t_stim_row;

    localparam int unsigned DIR_ROWS = 30;

    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        // reset values: header, plain bytes, sum and end byte
        '{ROW_BEAT, efe_pkg::REG_START, 8'h10, 1'b1, 1'b0, 3'd5, 56'hF0_02_00_00_10_00_00},
        '{ROW_BEAT, efe_pkg::REG_START, 8'hFF, 1'b0, 1'b0, 3'd1, 56'hFF_00_00_00_00_00_00},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h00, 1'b0, 1'b1, 3'd4, 56'h00_01_11_F1_00_00_00},
        // each marker as payload, escaped with the XOR mask
        '{ROW_BEAT, efe_pkg::REG_START, 8'hF0, 1'b1, 1'b0, 3'd6, 56'hF0_02_00_01_F2_02_00},
        '{ROW_BEAT, efe_pkg::REG_START, 8'hF1, 1'b0, 1'b1, 3'd5, 56'hF2_03_01_E3_F1_00_00},
        '{ROW_BEAT, efe_pkg::REG_START, 8'hF2, 1'b1, 1'b0, 3'd6, 56'hF0_02_00_02_F2_00_00},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h0D, 1'b0, 1'b1, 3'd4, 56'h0D_01_01_F1_00_00_00},
        // first and last together: last is dropped, the frame stays open
        '{ROW_BEAT, efe_pkg::REG_START, 8'hF1, 1'b1, 1'b1, 3'd6, 56'hF0_02_00_03_F2_03_00},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h20, 1'b0, 1'b0, 3'd0, 56'h0},
        // repeated first restarts the sum, the open frame gets no trailer
        '{ROW_BEAT, efe_pkg::REG_START, 8'h30, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h41, 1'b0, 1'b1, 3'd0, 56'h0},
        // last with no frame open, then a stray byte outside any frame
        '{ROW_BEAT, efe_pkg::REG_START, 8'h7F, 1'b0, 1'b1, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h80, 1'b0, 1'b0, 3'd0, 56'h0},
        // extreme register values; sum bytes now collide with the markers
        '{ROW_REG,  efe_pkg::REG_START,   8'h00, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_END,     8'h01, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_ESCAPE,  8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_COMMAND, 8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_ERROR,   8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h00, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h01, 1'b0, 1'b1, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'hFF, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'hFE, 1'b0, 1'b1, 3'd0, 56'h0},
        // all three markers equal
        '{ROW_REG,  efe_pkg::REG_START,   8'h55, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_END,     8'h55, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_ESCAPE,  8'h55, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_COMMAND, 8'h00, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_REG,  efe_pkg::REG_ERROR,   8'h00, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h55, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'h55, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_BEAT, efe_pkg::REG_START, 8'hAA, 1'b0, 1'b1, 3'd0, 56'h0}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [efe_pkg::BYTE_W-1:0]     i_data_byte;
    logic                           i_first_byte;
    logic                           i_last_byte;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [efe_pkg::BYTE_W-1:0]     o_out_byte;
    logic                           o_run_end;
    logic                           o_frame_end;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [efe_pkg::CFG_ADDR_W-1:0] paddr;
    logic [efe_pkg::CFG_DATA_W-1:0] pwdata;
    logic [efe_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // model copy of the registers and the frame state
    efe_pkg::t_cfg              enc_cfg;
    logic [efe_pkg::BYTE_W-1:0] seq_num;
    logic [efe_pkg::SUM_W-1:0]  frame_sum;

    t_enc_byte   beat_bytes[$];       // bytes one input beat produces
    t_enc_byte   frame_bytes_due[$];  // bytes still owed by the encoder, oldest first
    int unsigned fail_count;
    int unsigned cycle_count;
    t_idle_mode  idle_mode;
    bit          hold_req;

    escaped_frame_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_frame_end  (o_frame_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a stuck handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic void push_raw(input logic [efe_pkg::BYTE_W-1:0] b, input logic is_end);
        beat_bytes.push_back(t_enc_byte'{out_byte: b, run_end: 1'b0, frame_end: is_end});
    endfunction

    // a byte matching any marker goes out as escape, then byte XOR escape
    function automatic void push_escaped(input logic [efe_pkg::BYTE_W-1:0] b);
        if (b == enc_cfg.start_byte || b == enc_cfg.end_byte || b == enc_cfg.escape_byte) begin
            push_raw(enc_cfg.escape_byte, 1'b0);
            push_raw(b ^ enc_cfg.escape_byte, 1'b0);
        end else begin
            push_raw(b, 1'b0);
        end
    endfunction

    // Work out the bytes that one accepted input beat produces, and advance
    // the sequence number and the running sum.
    function automatic void encode_beat(input logic [efe_pkg::BYTE_W-1:0] d,
                                        input logic is_first, input logic is_last);
        logic close_frame;
        beat_bytes.delete();
        close_frame = is_last && !is_first;
        if (is_first) begin
            // header goes out raw, never escaped
            push_raw(enc_cfg.start_byte, 1'b0);
            push_raw(enc_cfg.command_byte, 1'b0);
            push_raw(enc_cfg.error_byte, 1'b0);
            push_raw(seq_num, 1'b0);
            seq_num   = seq_num + 8'd1;
            frame_sum = efe_pkg::SUM_W'(enc_cfg.command_byte)
                      + efe_pkg::SUM_W'(enc_cfg.error_byte);
        end
        frame_sum = frame_sum + efe_pkg::SUM_W'(d);
        push_escaped(d);
        if (close_frame) begin
            // trailer: sum high byte first, then the closing marker
            push_escaped(frame_sum[15:8]);
            push_escaped(frame_sum[7:0]);
            push_raw(enc_cfg.end_byte, 1'b1);
        end
        beat_bytes[beat_bytes.size()-1].run_end = 1'b1;
    endfunction

    // favour marker values so that escaping is hit often
    function automatic logic [efe_pkg::BYTE_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return enc_cfg.start_byte;
            1:       return enc_cfg.end_byte;
            2:       return enc_cfg.escape_byte;
            default: return efe_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one input beat and hold it until accepted. Valid is left high on
    // return; only an idle pattern of the sender drops it between beats. With n_typed
    // non-zero the typed bytes are owed instead of the model's; the model still advances.
    task automatic send_beat(input logic [efe_pkg::BYTE_W-1:0] d, input logic is_first,
                             input logic is_last, input logic [2:0] n_typed,
                             input logic [55:0] typed);
        t_enc_byte rec;
        while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 69) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= d;
        i_first_byte <= is_first;
        i_last_byte  <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
        encode_beat(d, is_first, is_last);
        if (n_typed == 3'd0) begin
            foreach (beat_bytes[k]) frame_bytes_due.push_back(beat_bytes[k]);
        end else begin
            for (int k = 0; k < int'(n_typed); k++) begin
                rec.out_byte  = typed[55-8*k -: 8];
                rec.run_end   = (k == int'(n_typed) - 1);
                rec.frame_end = rec.run_end && is_last && !is_first;
                frame_bytes_due.push_back(rec);
            end
        end
    endtask

    // Drop valid, wait for every owed byte, then let the pipeline settle.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then idle; pready is always high
    task automatic write_reg(input logic [2:0] idx, input logic [efe_pkg::BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= efe_pkg::CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            efe_pkg::REG_START:   enc_cfg.start_byte   = value;
            efe_pkg::REG_END:     enc_cfg.end_byte     = value;
            efe_pkg::REG_ESCAPE:  enc_cfg.escape_byte  = value;
            efe_pkg::REG_COMMAND: enc_cfg.command_byte = value;
            efe_pkg::REG_ERROR:   enc_cfg.error_byte   = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Sink side: check each accepted output beat against the oldest owed byte,
    // then pick the next ready. A requested hold-off is counted here.
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        logic        stall;
        t_enc_byte   due;
        i_out_ready = 1'b0;
        hold_left   = 0;
        hold_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("out_byte 0x%02h arrived with no byte owed", o_out_byte);
                    fail_count++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (o_out_byte !== due.out_byte) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               due.out_byte, o_out_byte);
                        fail_count++;
                    end
                    if (o_run_end !== due.run_end) begin
                        $error("run_end: expected %0b, got %0b", due.run_end, o_run_end);
                        fail_count++;
                    end
                    if (o_frame_end !== due.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", due.frame_end, o_frame_end);
                        fail_count++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                stall = 1'b1;
            end else begin
                stall = (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 69) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7);
            end
            i_out_ready <= i_rst_n && !stall;
        end
    end

    initial begin
        t_stim_row                  row;
        int unsigned                beats;
        int unsigned                flen;
        logic [efe_pkg::BYTE_W-1:0] new_start;
        logic [efe_pkg::BYTE_W-1:0] new_end;
        logic [efe_pkg::BYTE_W-1:0] new_escape;
        logic [efe_pkg::BYTE_W-1:0] new_command;
        logic [efe_pkg::BYTE_W-1:0] new_error;

        // every input known from time zero
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_first_byte = 1'b0;
        i_last_byte  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_mode    = IDLE_NONE;
        hold_req     = 1'b0;
        fail_count   = 0;
        enc_cfg      = '{start_byte: efe_pkg::RST_START, end_byte: efe_pkg::RST_END,
                         escape_byte: efe_pkg::RST_ESCAPE,
                         command_byte: efe_pkg::RST_COMMAND,
                         error_byte: efe_pkg::RST_ERROR};
        seq_num      = '0;
        frame_sum    = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: walk the table; register rows wait for the encoder
        // to go idle before the write.
        foreach (DIR_TABLE[r]) begin
            row = DIR_TABLE[r];
            if (row.kind == ROW_REG) begin
                drain_and_settle();
                write_reg(row.reg_idx, row.value);
            end else begin
                send_beat(row.value, row.is_first, row.is_last, row.n_typed, row.typed);
            end
        end
        drain_and_settle();

        // Random part: each phase takes a fresh register setting and an idle
        // pattern, then mostly well-formed frames with a sprinkle of noise.
        for (int p = 0; p < int'(NUM_PHASES); p++) begin
            idle_mode = t_idle_mode'(p % 4);
            case ($urandom_range(0, 3))
                0: begin
                    new_start   = efe_pkg::RST_START;
                    new_end     = efe_pkg::RST_END;
                    new_escape  = efe_pkg::RST_ESCAPE;
                    new_command = efe_pkg::RST_COMMAND;
                    new_error   = efe_pkg::RST_ERROR;
                end
                1: begin
                    new_start   = efe_pkg::BYTE_W'($urandom_range(0, 255));
                    new_end     = efe_pkg::BYTE_W'($urandom_range(0, 255));
                    new_escape  = efe_pkg::BYTE_W'($urandom_range(0, 255));
                    new_command = efe_pkg::BYTE_W'($urandom_range(0, 255));
                    new_error   = efe_pkg::BYTE_W'($urandom_range(0, 255));
                end
                2: begin
                    // small markers and header: sum high bytes hit the markers
                    new_start   = efe_pkg::BYTE_W'($urandom_range(0, 3));
                    new_end     = efe_pkg::BYTE_W'($urandom_range(0, 3));
                    new_escape  = efe_pkg::BYTE_W'($urandom_range(0, 3));
                    new_command = efe_pkg::BYTE_W'($urandom_range(0, 3));
                    new_error   = efe_pkg::BYTE_W'($urandom_range(0, 3));
                end
                default: begin
                    new_start   = efe_pkg::BYTE_W'($urandom_range(0, 255));
                    new_end     = new_start;
                    new_escape  = new_start;
                    new_command = 8'hFF;
                    new_error   = efe_pkg::BYTE_W'($urandom_range(0, 255));
                end
            endcase
            write_reg(efe_pkg::REG_START, new_start);
            write_reg(efe_pkg::REG_END, new_end);
            write_reg(efe_pkg::REG_ESCAPE, new_escape);
            write_reg(efe_pkg::REG_COMMAND, new_command);
            write_reg(efe_pkg::REG_ERROR, new_error);

            // hold the sink off for a long stretch while beats keep coming,
            // so the job queue fills and the input stalls
            if (p == 4) hold_req = 1'b1;

            beats = 0;
            while (beats < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_beat(pick_data(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 3'd0, 56'h0);
                    beats++;
                end else begin
                    flen = $urandom_range(2, 8);
                    for (int k = 0; k < int'(flen); k++) begin
                        send_beat(pick_data(), k == 0, k == int'(flen) - 1, 3'd0, 56'h0);
                    end
                    beats += flen;
                end
            end
            // pause the sender until every owed byte is out
            drain_and_settle();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
